/* design/double_ended_queue_unit_macros.svh */
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// invariant checked at every edge out of reset
`define DQU_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// implication checked at every edge out of reset
`define DQU_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* design/dqu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dqu_pkg;

   localparam int DEPTH_DEFAULT = 1024;
   localparam int DATA_W        = 32;
   localparam int COUNT_W       = 11;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5,
      OP_CLEAR      = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]               op;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [1:0]               status;
      logic [COUNT_W-1:0]       count;
   } rsp_type;

endpackage

`default_nettype wire

/* design/double_ended_queue_unit.sv */
// a word accepted reads the store into rd_ff with stage 1; out_ff then takes it and drives rsp
// throughput: one word per cycle unless stalled; one store port, at most one read or write per word
// stall: a held result holds the word behind it, req_ready drops only then
// reset (synchronous, active high) clears head, count and both stage valids
// the entry store is not cleared; entries are read only after they are written
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_unit
   import dqu_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_POS  = AW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
   localparam logic [CW:0]   DEPTH_SUM = (CW + 1)'(DEPTH);

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_ff;

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;

   // stage 1: store access done, waiting for read data
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_read_ff, s1_read_in;
   status_type    s1_status_ff, s1_status_in;
   logic [CW-1:0] s1_count_ff;

   logic          out_valid_ff, out_valid_in;
   rsp_type       out_ff;

   logic          accept, out_load;
   logic          wr_en, rd_en;
   logic [AW-1:0] addr;
   logic [CW:0]   back_sum, back_last_sum;
   logic [AW-1:0] back_pos, back_last_pos;
   logic [31:0]   count_wide;

   assign out_load  = !out_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_load;
   assign accept    = req_valid && req_ready;

   // ring positions: sums stay below twice the depth, one subtract wraps them
   always_comb begin
      back_sum      = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
      back_last_sum = back_sum - (CW + 1)'(1);
      back_pos      = (back_sum >= DEPTH_SUM) ? AW'(back_sum - DEPTH_SUM) : AW'(back_sum);
      back_last_pos = (back_last_sum >= DEPTH_SUM) ?
                      AW'(back_last_sum - DEPTH_SUM) : AW'(back_last_sum);
   end

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      addr         = head_ff;
      s1_read_in   = 1'b0;
      s1_status_in = ST_OK;
      case (req_payload.op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (count_ff == DEPTH_CNT) begin
               s1_status_in = ST_FULL;
            end else begin
               wr_en    = accept;
               count_in = count_ff + CW'(1);
               if (req_payload.op == OP_PUSH_FRONT) begin
                  addr    = (head_ff == '0) ? LAST_POS : head_ff - AW'(1);
                  head_in = addr;
               end else begin
                  addr = back_pos;
               end
            end
         end
         OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
            if (count_ff == '0) begin
               s1_status_in = ST_EMPTY;
            end else begin
               rd_en      = accept;
               s1_read_in = 1'b1;
               if (req_payload.op == OP_POP_FRONT || req_payload.op == OP_PEEK_FRONT) begin
                  addr = head_ff;
               end else begin
                  addr = back_last_pos;
               end
               if (req_payload.op == OP_POP_FRONT) begin
                  head_in  = (head_ff == LAST_POS) ? '0 : head_ff + AW'(1);
                  count_in = count_ff - CW'(1);
               end else if (req_payload.op == OP_POP_BACK) begin
                  count_in = count_ff - CW'(1);
               end
            end
         end
         OP_CLEAR: begin
            head_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= req_payload.value;
      end
      if (rd_en) begin
         rd_ff <= mem[addr];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (accept) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
      end
   end

   assign count_wide = 32'(s1_count_ff);

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_read_ff   <= s1_read_in;
         s1_status_ff <= s1_status_in;
         s1_count_ff  <= count_in;
      end
      if (out_load && s1_valid_ff) begin
         out_ff.data   <= s1_read_ff ? rd_ff : '0;
         out_ff.status <= s1_status_ff;
         out_ff.count  <= count_wide[COUNT_W-1:0];
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

`include "double_ended_queue_unit_macros.svh"

   `DQU_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= DEPTH_CNT, "count above depth")
   `DQU_ASSERT_ALWAYS(a_head_bound, clock, reset, head_ff <= LAST_POS, "head outside ring")
   `DQU_ASSERT_IMPLY(a_hold_blocks, clock, reset, s1_valid_ff && !out_load, !req_ready,
      "word taken while stage 1 is held")
   `DQU_ASSERT_IMPLY(a_full_count, clock, reset, s1_valid_ff && s1_status_ff == ST_FULL,
      s1_count_ff == DEPTH_CNT, "full status with room left")
   `DQU_ASSERT_IMPLY(a_empty_count, clock, reset, s1_valid_ff && s1_status_ff == ST_EMPTY,
      s1_count_ff == '0 && !s1_read_ff, "empty status with entries stored")

endmodule

`default_nettype wire

/* tb/deque_check.sv */
`timescale 1ns / 1ps

module deque_check
   import dqu_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      owed_count,
   output int      words_checked,
   output int      empty_seen,
   output int      full_seen,
   output int      peak_level
);

   localparam int RW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DUE_DEPTH = 16;

   logic signed [DATA_W-1:0] ring [DEPTH];
   int      head;
   int      level;
   rsp_type due_fifo [DUE_DEPTH];
   logic [3:0] due_wr_ptr;
   logic [3:0] due_rd_ptr;
   int      due_level;
   rsp_type due_rsp;
   rsp_type next_rsp;
   logic    bad_word;

   // applies one operation to the shadow deque and returns the word it should answer with
   function automatic rsp_type apply_deque_op(input req_type w);
      rsp_type r;
      int      pos;
      r.data   = '0;
      r.status = ST_OK;
      case (w.op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (level >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               if (w.op == OP_PUSH_FRONT) begin
                  head = (head + DEPTH - 1) % DEPTH;
                  pos  = head;
               end else begin
                  pos = (head + level) % DEPTH;
               end
               ring[RW'(pos)] = w.value;
               level++;
            end
         end
         OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
            if (level == 0) begin
               r.status = ST_EMPTY;
            end else begin
               pos = (w.op == OP_POP_FRONT || w.op == OP_PEEK_FRONT) ?
                     head : (head + level - 1) % DEPTH;
               r.data = ring[RW'(pos)];
               if (w.op == OP_POP_FRONT) begin
                  head = (head + 1) % DEPTH;
                  level--;
               end else if (w.op == OP_POP_BACK) begin
                  level--;
               end
            end
         end
         OP_CLEAR: begin
            head  = 0;
            level = 0;
         end
         default: ;
      endcase
      r.count = level[COUNT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         head          = 0;
         level         = 0;
         due_wr_ptr    = '0;
         due_rd_ptr    = '0;
         due_level     = 0;
         fail_count    = 0;
         owed_count    = 0;
         words_checked = 0;
         empty_seen    = 0;
         full_seen     = 0;
         peak_level    = 0;
      end else begin
         if (req_valid && req_ready) begin
            next_rsp = apply_deque_op(req_payload);
            if (due_level >= DUE_DEPTH) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("too many words in flight: %0d", due_level);
            end else begin
               due_fifo[due_wr_ptr] = next_rsp;
               due_wr_ptr = due_wr_ptr + 4'd1;
               due_level++;
            end
            if (next_rsp.status == ST_EMPTY) empty_seen++;
            if (next_rsp.status == ST_FULL) full_seen++;
            if (level > peak_level) peak_level = level;
         end
         if (rsp_valid && rsp_ready) begin
            words_checked++;
            if (due_level == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected word: data %0d status %0d count %0d",
                           rsp_payload.data, rsp_payload.status, rsp_payload.count);
            end else begin
               due_rsp    = due_fifo[due_rd_ptr];
               due_rd_ptr = due_rd_ptr + 4'd1;
               due_level--;
               bad_word = (rsp_payload.data !== due_rsp.data) ||
                          (rsp_payload.status !== due_rsp.status) ||
                          (rsp_payload.count !== due_rsp.count);
               if (bad_word) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch on word %0d: data %0d/%0d status %0d/%0d count %0d/%0d",
                              words_checked, due_rsp.data, rsp_payload.data,
                              due_rsp.status, rsp_payload.status,
                              due_rsp.count, rsp_payload.count);
               end
            end
         end
         owed_count = due_level;
      end
   end

endmodule

/* tb/double_ended_queue_unit_tb.sv */
`timescale 1ns / 1ps

module double_ended_queue_unit_tb;
   import dqu_pkg::*;

   localparam int HALF_PERIOD      = 4;
   localparam int RESET_CYCLES     = 12;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int HOLD_CYCLES      = 400;
   localparam int SETTLE_CYCLES    = 10;
   localparam int RANDOM_PER_PHASE = 140;
   localparam int BURST_WORDS      = 240;
   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam logic signed [DATA_W-1:0] MAX_WORD = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] MIN_WORD = 32'sh8000_0000;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   bit hold_off_req  = 1'b0;
   int cycles        = 0;
   int hold_cnt;
   int fail_count, owed_count, words_checked, empty_seen, full_seen, peak_level;

   // idle mixes per random phase: none, sender, receiver, both
   int idle_mix [4] = '{0, 73, 0, 21};
   int stall_mix [4] = '{0, 0, 73, 21};
   int push_mix [4] = '{45, 35, 55, 40};

   always #HALF_PERIOD clock = ~clock;

   double_ended_queue_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   deque_check u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .fail_count    (fail_count),
      .owed_count    (owed_count),
      .words_checked (words_checked),
      .empty_seen    (empty_seen),
      .full_seen     (full_seen),
      .peak_level    (peak_level)
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) begin
               rsp_ready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_word(input logic [2:0] op, input logic signed [DATA_W-1:0] value);
      req_type w;
      w.op    = op;
      w.value = value;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic signed [DATA_W-1:0] random_value();
      case ($urandom_range(15))
         0: return MAX_WORD;
         1: return MIN_WORD;
         2: return '0;
         3: return -1;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_random(input int push_pct);
      logic [2:0] op;
      int         r;
      r = $urandom_range(99);
      if (r < push_pct) op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      else if (r < 93) op = 3'($urandom_range(OP_PEEK_BACK, OP_POP_FRONT));
      else if (r < 97) op = OP_CLEAR;
      else op = OP_UNUSED;
      send_word(op, random_value());
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty queue, extremes at both ends, unused code, clear
      send_word(OP_POP_FRONT, 0);
      send_word(OP_POP_BACK, -1);
      send_word(OP_PEEK_FRONT, MAX_WORD);
      send_word(OP_PEEK_BACK, MIN_WORD);
      send_word(OP_PUSH_FRONT, MAX_WORD);
      send_word(OP_PUSH_BACK, MIN_WORD);
      send_word(OP_PUSH_FRONT, -1);
      send_word(OP_PUSH_BACK, 0);
      send_word(OP_PEEK_FRONT, 0);
      send_word(OP_PEEK_BACK, 0);
      send_word(OP_UNUSED, random_value());
      send_word(OP_POP_FRONT, 0);
      send_word(OP_POP_BACK, 0);
      send_word(OP_POP_FRONT, 0);
      send_word(OP_POP_BACK, 0);
      send_word(OP_POP_BACK, 0);
      send_word(OP_PUSH_BACK, 32'sh5555_5555);
      send_word(OP_PUSH_FRONT, 32'shaaaa_aaaa);
      send_word(OP_CLEAR, random_value());
      send_word(OP_PEEK_FRONT, 0);
      send_word(OP_PUSH_BACK, 1);
      send_word(OP_POP_FRONT, 0);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_mix[ph];
         stall_pct     = stall_mix[ph];
         repeat (RANDOM_PER_PHASE) send_random(push_mix[ph]);
      end

      // push burst against a stalled receiver so the input backs up
      send_idle_pct = 0;
      stall_pct     = 21;
      send_word(OP_CLEAR, random_value());
      hold_off_req = 1'b1;
      repeat (BURST_WORDS)
         send_word($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, random_value());
      repeat (30) send_random(50);
      send_word(OP_CLEAR, random_value());

      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("checked %0d words: %0d empty refusals, %0d full refusals, peak occupancy %0d",
               words_checked, empty_seen, full_seen, peak_level);
      $display("idle mixes none/sender/receiver/both, plus a %0d-cycle receiver hold-off",
               HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
